// File: sv/sst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set table package
// Shared sizes, operation codes, controller states and the cell command.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int DEPTH     = 64;
    localparam int VAL_W     = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CAP_W     = 7;
    localparam int OUT_CNT_W = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic             cmp_en;
        logic             ins_en;
        logic             del_en;
        logic [VAL_W-1:0] value;
    } cell_cmd_t;

endpackage

// File: sv/sorted_set_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set table core
// A set of distinct signed 32-bit values kept in ascending order in a row of
// cells, with lookup, insert and delete commands.
// ----------------------------------------------------------------------------
// Each input beat carries a value on s_tdata and the command on s_tuser
// (lookup, insert or delete). Each command gives exactly one result beat with
// the found flag, the position of the value (or the count before the command
// when absent), the count after it and a status that flags an insert refused
// because the table has reached its capacity limit.
// The result beat is registered at the end of the update state: in the
// compare state every cell compares its entry with the value, in the
// update state the cells shift towards or away from the insertion point and
// the result is registered. A command passes through the idle, compare and
// update states and only one is in flight at a time, so the block does not
// accept a new beat until the previous command has been completed.
// The result register waits for m_tready; while it is still full the update
// cycle is held, and the next beat is not accepted until the update is done.
// The capacity limit is written through the cfg channel, which is always
// ready, and should only be written while no command is in flight.
// Reset empties the table and sets the capacity limit to 64.
// ----------------------------------------------------------------------------
module sorted_set_table_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // [31:0] value
    input  logic [1:0]                    s_tuser,   // [1:0] operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // [0] found, [7:1] position,
                                                     // [14:8] count, [15] status
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sst_pkg::CAP_W-1:0]     cfg_data
);

    sst_pkg::cell_cmd_t                   cmd;
    logic [sst_pkg::DEPTH-1:0]            lt_vec;
    logic [sst_pkg::DEPTH-1:0]            eq_vec;
    logic [sst_pkg::DEPTH-1:0]            occupied;
    logic [sst_pkg::VAL_W-1:0]            entry_vec [sst_pkg::DEPTH];
    logic                                 m_found;
    logic [sst_pkg::OUT_CNT_W-1:0]        m_position;
    logic [sst_pkg::OUT_CNT_W-1:0]        m_count;
    logic                                 m_status;

    sst_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_op       (s_tuser),
        .s_value    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .eq_vec     (eq_vec),
        .occupied   (occupied),
        .cmd        (cmd),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_found    (m_found),
        .m_position (m_position),
        .m_count    (m_count),
        .m_status   (m_status)
    );

    for (genvar i = 0; i < sst_pkg::DEPTH; i++) begin : g_cell
        logic                      left_lt;
        logic [sst_pkg::VAL_W-1:0] left_entry;
        logic [sst_pkg::VAL_W-1:0] right_entry;

        if (i == 0) begin : g_first
            assign left_lt    = 1'b1;
            assign left_entry = '0;
        end else begin : g_inner
            assign left_lt    = lt_vec[i-1];
            assign left_entry = entry_vec[i-1];
        end

        if (i == sst_pkg::DEPTH - 1) begin : g_last
            assign right_entry = entry_vec[i];
        end else begin : g_body
            assign right_entry = entry_vec[i+1];
        end

        sst_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .occupied    (occupied[i]),
            .left_lt     (left_lt),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entry_vec[i]),
            .lt          (lt_vec[i]),
            .eq          (eq_vec[i])
        );
    end

    assign m_tdata = {m_status, m_count, m_position, m_found};

endmodule

// File: sv/sst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set table cell
// Holds one entry, compares it with the key and shifts with its neighbours.
// ----------------------------------------------------------------------------
module sst_cell (
    input  logic                          aclk,
    input  sst_pkg::cell_cmd_t            cmd,
    input  logic                          occupied,
    input  logic                          left_lt,
    input  logic [sst_pkg::VAL_W-1:0]     left_entry,
    input  logic [sst_pkg::VAL_W-1:0]     right_entry,
    output logic [sst_pkg::VAL_W-1:0]     entry,
    output logic                          lt,
    output logic                          eq
);

    logic [sst_pkg::VAL_W-1:0] entry_reg;
    logic [sst_pkg::VAL_W-1:0] entry_next;
    logic                      lt_reg;
    logic                      eq_reg;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.ins_en && !lt_reg) begin
            entry_next = left_lt ? cmd.value : left_entry;
        end else if (cmd.del_en && !lt_reg) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (cmd.cmp_en) begin
            lt_reg <= occupied && ($signed(entry_reg) < $signed(cmd.value));
            eq_reg <= occupied && (entry_reg == cmd.value);
        end
    end

    assign entry = entry_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

// File: sv/sst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set table controller
// Sequences compare and update, keeps the count and builds the result beat.
// ----------------------------------------------------------------------------
module sst_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [1:0]                      s_op,
    input  logic [sst_pkg::VAL_W-1:0]       s_value,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sst_pkg::CAP_W-1:0]       cfg_data,
    input  logic [sst_pkg::DEPTH-1:0]       eq_vec,
    output logic [sst_pkg::DEPTH-1:0]       occupied,
    output sst_pkg::cell_cmd_t              cmd,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic                            m_found,
    output logic [sst_pkg::OUT_CNT_W-1:0]   m_position,
    output logic [sst_pkg::OUT_CNT_W-1:0]   m_count,
    output logic                            m_status
);

    sst_pkg::state_t                state_reg;
    sst_pkg::state_t                state_next;
    sst_pkg::op_t                   op_reg;
    logic [sst_pkg::VAL_W-1:0]      value_reg;
    logic [sst_pkg::CNT_W-1:0]      count_reg;
    logic [sst_pkg::CNT_W-1:0]      count_next;
    logic [sst_pkg::CAP_W-1:0]      cap_reg;
    logic                           m_valid_reg;
    logic                           m_found_reg;
    logic [sst_pkg::OUT_CNT_W-1:0]  m_position_reg;
    logic [sst_pkg::OUT_CNT_W-1:0]  m_count_reg;
    logic                           m_status_reg;

    logic                           out_free;
    logic                           accept;
    logic                           update;
    logic                           cmp_en;
    logic                           found;
    logic [sst_pkg::IDX_W-1:0]      hit_idx;
    logic [sst_pkg::CNT_W-1:0]      limit;
    logic                           full;
    logic                           do_insert;
    logic                           do_delete;
    logic                           status;
    logic [sst_pkg::CNT_W-1:0]      position;

    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sst_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = sst_pkg::ST_COMPARE;
                end
            end
            sst_pkg::ST_COMPARE: begin
                state_next = sst_pkg::ST_UPDATE;
            end
            sst_pkg::ST_UPDATE: begin
                if (out_free) begin
                    state_next = sst_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sst_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmp_en   = 1'b0;
        update   = 1'b0;
        case (state_reg)
            sst_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            sst_pkg::ST_COMPARE: begin
                cmp_en = 1'b1;
            end
            sst_pkg::ST_UPDATE: begin
                update = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < sst_pkg::DEPTH; i++) begin
            if (eq_vec[i]) begin
                hit_idx = hit_idx | sst_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < sst_pkg::DEPTH; i++) begin
            occupied[i] = sst_pkg::CNT_W'(i) < count_reg;
        end
    end

    assign found    = |eq_vec;
    assign limit    = (32'(cap_reg) < sst_pkg::DEPTH) ? sst_pkg::CNT_W'(cap_reg)
                                                       : sst_pkg::CNT_W'(sst_pkg::DEPTH);
    assign full     = count_reg >= limit;
    assign status   = (op_reg == sst_pkg::OP_INSERT) && full;
    assign do_insert = update && (op_reg == sst_pkg::OP_INSERT) && !full && !found;
    assign do_delete = update && (op_reg == sst_pkg::OP_DELETE) && found;
    assign position = found ? sst_pkg::CNT_W'(hit_idx) : count_reg;

    always_comb begin
        count_next = count_reg;
        if (do_insert) begin
            count_next = count_reg + sst_pkg::CNT_W'(1);
        end else if (do_delete) begin
            count_next = count_reg - sst_pkg::CNT_W'(1);
        end
    end

    assign cmd = {cmp_en, do_insert, do_delete, value_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sst_pkg::ST_IDLE;
            count_reg   <= '0;
            cap_reg     <= sst_pkg::CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
            if (update) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= sst_pkg::op_t'(s_op);
            value_reg <= s_value;
        end
        if (update) begin
            m_found_reg    <= found;
            m_position_reg <= sst_pkg::OUT_CNT_W'(position);
            m_count_reg    <= sst_pkg::OUT_CNT_W'(count_next);
            m_status_reg   <= status;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_found    = m_found_reg;
    assign m_position = m_position_reg;
    assign m_count    = m_count_reg;
    assign m_status   = m_status_reg;

endmodule
